### design/lz78_pkg.sv
// Shared types and constants for the LZ78 token decoder.
// No dependencies; compiled first.
package lz78_pkg;

  localparam int DICT_DEPTH_DEF = 4096;
  localparam int MAX_STRING_DEF = 64;
  localparam int IDX_W          = 16;
  localparam int SYM_W          = 8;
  localparam int LEN_W          = 7;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_INDEX = 2'd1,
    ST_TOO_LONG  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOKUP,
    S_WALK,
    S_EMIT,
    S_ERR
  } state_t;

  typedef struct packed {
    logic [IDX_W-1:0] parent;
    logic [SYM_W-1:0] symbol;
    logic [LEN_W-1:0] length;
  } dict_entry_t;

endpackage

### design/lz78_tok_if.sv
// Token channel: valid/ready handshake with prefix index, symbol and stream end.
// Depends on lz78_pkg.
interface lz78_tok_if;
  import lz78_pkg::*;

  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] prefix_index;
  logic [SYM_W-1:0] symbol;
  logic             stream_end;

  modport source (output valid, prefix_index, symbol, stream_end, input ready);
  modport sink   (input valid, prefix_index, symbol, stream_end, output ready);
endinterface

### design/lz78_res_if.sv
// Result channel: valid/ready handshake with one decoded byte and its flags.
// Depends on lz78_pkg.
interface lz78_res_if;
  import lz78_pkg::*;

  logic             valid;
  logic             ready;
  logic [SYM_W-1:0] out_byte;
  logic             token_last;
  logic             stream_last;
  status_t          status;

  modport source (output valid, out_byte, token_last, stream_last, status, input ready);
  modport sink   (input valid, out_byte, token_last, stream_last, status, output ready);
endinterface

### design/lz78_token_decoder_core.sv
// LZ78 token decoder: dictionary memory, parent-chain walk, byte read-out.
// Depends on lz78_pkg, lz78_tok_if and lz78_res_if.
//
//   channel  | dir | payload                                       | transfer
//   ---------+-----+-----------------------------------------------+------------------
//   token    | in  | prefix_index[15:0], symbol[7:0], stream_end   | valid & ready
//   result   | out | out_byte[7:0], token_last, stream_last, status | valid & ready
//
// A token of string length L is handled in steps: accept, one dictionary read for the
// prefix length (skipped for an empty prefix), L-1 parent-chain steps (one dictionary
// read per step) plus one that primes the read-out, then L bytes read out of the
// reverse buffer, one per cycle while the result is not stalled.
// An invalid or too-long token gives one error result; later tokens of its stream are discarded.
// Reset clears the entry count and the discard flag; the memories need no clearing.
// A stalled result holds the read-out; a new token is taken while the last result waits.
module lz78_token_decoder_core
  import lz78_pkg::*;
#(
  parameter int DICT_DEPTH = lz78_pkg::DICT_DEPTH_DEF,
  parameter int MAX_STRING = lz78_pkg::MAX_STRING_DEF
) (
  input logic         clk,
  input logic         rst,
  lz78_tok_if.sink    token,
  lz78_res_if.source  result
);

  localparam int AW = $clog2(DICT_DEPTH);
  localparam int CW = $clog2(DICT_DEPTH + 1);
  localparam int RW = $clog2(MAX_STRING);
  localparam int LW = $clog2(MAX_STRING + 1);

  // storage
  dict_entry_t      dict [DICT_DEPTH];
  logic [SYM_W-1:0] rbuf [MAX_STRING];
  dict_entry_t      rd_q;
  logic [SYM_W-1:0] rb_q;

  // control registers
  state_t           state, state_next;
  logic [CW-1:0]    entry_count;
  logic             discarding;
  logic [IDX_W-1:0] cur_p;
  logic [SYM_W-1:0] tok_sym;
  logic             tok_last;
  logic [LW-1:0]    len;
  logic [RW-1:0]    pos;
  logic [RW-1:0]    emit_ptr;
  status_t          err_code;

  // output register
  logic             res_valid;
  logic [SYM_W-1:0] res_byte;
  logic             res_tlast;
  logic             res_slast;
  status_t          res_status;

  // combinational controls
  logic             tok_fire;
  logic             idx_bad;
  logic [LEN_W:0]   plen_sum;
  logic             too_long;
  logic             walk_done;
  logic             slot_free;
  logic             emit_final;
  logic             dict_full;

  logic             mem_rd_en;
  logic [AW-1:0]    mem_rd_addr;
  logic             mem_wr_en;
  logic [AW-1:0]    mem_wr_addr;
  dict_entry_t      mem_wr_data;
  logic             rb_wr_en;
  logic [RW-1:0]    rb_wr_addr;
  logic [SYM_W-1:0] rb_wr_data;
  logic             rb_rd_en;
  logic [RW-1:0]    rb_rd_addr;
  logic             load_out;
  logic [SYM_W-1:0] load_byte;
  logic             load_tlast;
  logic             load_slast;
  status_t          load_status;
  logic             cnt_clear;
  logic             cnt_inc;

  assign token.ready  = (state == S_IDLE) && !rst;
  assign tok_fire     = token.valid && token.ready;
  assign idx_bad      = token.prefix_index > IDX_W'(entry_count);
  assign plen_sum     = {1'b0, rd_q.length} + (LEN_W+1)'(1);
  assign too_long     = plen_sum > (LEN_W+1)'(MAX_STRING);
  assign walk_done    = (cur_p == '0) || (pos == '0);
  assign slot_free    = !res_valid || result.ready;
  assign emit_final   = emit_ptr == RW'(len - LW'(1));
  assign dict_full    = entry_count == CW'(DICT_DEPTH);

  assign result.valid       = res_valid;
  assign result.out_byte    = res_byte;
  assign result.token_last  = res_tlast;
  assign result.stream_last = res_slast;
  assign result.status      = res_status;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (tok_fire && !discarding) begin
          if (idx_bad) state_next = S_ERR;
          else if (token.prefix_index == '0) state_next = S_WALK;
          else state_next = S_LOOKUP;
        end
      end
      S_LOOKUP: state_next = too_long ? S_ERR : S_WALK;
      S_WALK:   if (walk_done) state_next = S_EMIT;
      S_EMIT:   if (slot_free && emit_final) state_next = S_IDLE;
      S_ERR:    if (slot_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // datapath controls
  always_comb begin
    mem_rd_en   = 1'b0;
    mem_rd_addr = AW'(cur_p - IDX_W'(1));
    mem_wr_en   = 1'b0;
    mem_wr_addr = AW'(entry_count);
    mem_wr_data = '{parent: cur_p, symbol: tok_sym, length: LEN_W'(plen_sum)};
    rb_wr_en    = 1'b0;
    rb_wr_addr  = RW'(pos - RW'(1));
    rb_wr_data  = rd_q.symbol;
    rb_rd_en    = 1'b0;
    rb_rd_addr  = '0;
    load_out    = 1'b0;
    load_byte   = rb_q;
    load_tlast  = emit_final;
    load_slast  = emit_final && tok_last;
    load_status = ST_OK;
    cnt_clear   = 1'b0;
    cnt_inc     = 1'b0;
    case (state)
      S_IDLE: begin
        if (tok_fire) begin
          if (discarding || idx_bad) begin
            cnt_clear = token.stream_end;
          end else if (token.prefix_index != '0) begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = AW'(token.prefix_index - IDX_W'(1));
          end else begin
            // empty prefix: the string is the symbol alone
            rb_wr_en    = 1'b1;
            rb_wr_addr  = '0;
            rb_wr_data  = token.symbol;
            mem_wr_en   = !dict_full;
            mem_wr_data = '{parent: '0, symbol: token.symbol, length: LEN_W'(1)};
            cnt_clear   = token.stream_end;
            cnt_inc     = !dict_full;
          end
        end
      end
      S_LOOKUP: begin
        if (too_long) begin
          cnt_clear = tok_last;
        end else begin
          rb_wr_en   = 1'b1;
          rb_wr_addr = RW'(plen_sum - (LEN_W+1)'(1));
          rb_wr_data = tok_sym;
          mem_wr_en  = !dict_full;
          cnt_clear  = tok_last;
          cnt_inc    = !dict_full;
        end
      end
      S_WALK: begin
        if (!walk_done) begin
          rb_wr_en    = 1'b1;
          mem_rd_en   = rd_q.parent != '0;
          mem_rd_addr = AW'(rd_q.parent - IDX_W'(1));
        end else begin
          // prime the read-out with the first byte
          rb_rd_en = 1'b1;
        end
      end
      S_EMIT: begin
        if (slot_free) begin
          load_out = 1'b1;
          if (!emit_final) begin
            rb_rd_en   = 1'b1;
            rb_rd_addr = RW'(emit_ptr + RW'(1));
          end
        end
      end
      S_ERR: begin
        load_out    = slot_free;
        load_byte   = '0;
        load_tlast  = 1'b1;
        load_slast  = 1'b1;
        load_status = err_code;
      end
      default: ;
    endcase
  end

  // memories
  always_ff @(posedge clk) begin
    if (mem_wr_en) dict[mem_wr_addr] <= mem_wr_data;
    if (mem_rd_en) rd_q <= dict[mem_rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rb_wr_en) rbuf[rb_wr_addr] <= rb_wr_data;
    if (rb_rd_en) rb_q <= rbuf[rb_rd_addr];
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      entry_count <= '0;
      discarding  <= 1'b0;
      res_valid   <= 1'b0;
    end else begin
      state <= state_next;

      if (cnt_clear) entry_count <= '0;
      else if (cnt_inc) entry_count <= entry_count + CW'(1);

      if (tok_fire) begin
        if (discarding) begin
          if (token.stream_end) discarding <= 1'b0;
        end else if (idx_bad) begin
          discarding <= !token.stream_end;
        end
      end
      if (state == S_LOOKUP && too_long) discarding <= !tok_last;

      if (load_out) res_valid <= 1'b1;
      else if (result.ready) res_valid <= 1'b0;
    end
  end

  // token and walk registers
  always_ff @(posedge clk) begin
    if (tok_fire) begin
      tok_sym  <= token.symbol;
      tok_last <= token.stream_end;
      cur_p    <= token.prefix_index;
      err_code <= ST_BAD_INDEX;
      len      <= LW'(1);
      pos      <= '0;
    end
    case (state)
      S_LOOKUP: begin
        err_code <= ST_TOO_LONG;
        len      <= LW'(plen_sum);
        pos      <= RW'(plen_sum - (LEN_W+1)'(1));
      end
      S_WALK: begin
        if (!walk_done) begin
          pos   <= pos - RW'(1);
          cur_p <= rd_q.parent;
        end
        emit_ptr <= '0;
      end
      S_EMIT: begin
        if (slot_free && !emit_final) emit_ptr <= emit_ptr + RW'(1);
      end
      default: ;
    endcase
    if (load_out) begin
      res_byte   <= load_byte;
      res_tlast  <= load_tlast;
      res_slast  <= load_slast;
      res_status <= load_status;
    end
  end

endmodule

### design/lz78_checker.sv
// Port-level checks for the LZ78 token decoder, bound to its top level.
// Depends on lz78_pkg.
module lz78_checker
  import lz78_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             tok_ready,
  input logic             res_valid,
  input logic             res_ready,
  input logic [SYM_W-1:0] res_byte,
  input logic             res_tlast,
  input logic             res_slast,
  input logic [1:0]       res_status
);

  // a stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_byte) && $stable(res_tlast)
      && $stable(res_slast) && $stable(res_status))
    else $error("stalled result changed");

  // error results are single, zero and close the stream
  assert property (@(posedge clk) disable iff (rst)
    res_valid && res_status != ST_OK |->
      res_byte == '0 && res_tlast && res_slast
      && (res_status == ST_BAD_INDEX || res_status == ST_TOO_LONG))
    else $error("malformed error result");

  assert property (@(posedge clk) disable iff (rst)
    res_valid && res_slast |-> res_tlast)
    else $error("stream end not on token end");

  // no new token while a string is still being emitted
  assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_tlast |-> !tok_ready)
    else $error("token taken mid-string");

endmodule

bind lz78_token_decoder_core lz78_checker u_lz78_checker (
  .clk        (clk),
  .rst        (rst),
  .tok_ready  (token.ready),
  .res_valid  (result.valid),
  .res_ready  (result.ready),
  .res_byte   (result.out_byte),
  .res_tlast  (result.token_last),
  .res_slast  (result.stream_last),
  .res_status (result.status)
);
